@@ design/cfm_pkg.sv @@
// cfm_pkg: types, register codes and constants for the comms fault monitor.
// No dependencies; used by every other design file except cfm_stream_if and cfm_debounce.

package cfm_pkg;

    // Item fields on the tick channel
    typedef struct packed {
        logic       esc_rx;
        logic       bms_rx;
        logic       ble_rx;
        logic [7:0] motor_error;
        logic [7:0] motor_temp;
        logic [7:0] ctrl_temp;
        logic       vehicle_ready;
        logic       charging;
        logic       pack_warn_a;
        logic       pack_warn_b;
    } tick_item_t;

    localparam int unsigned FLAG_W = 13;

    // Item fields on the result channel
    typedef struct packed {
        logic [FLAG_W-1:0] fault_flags;
        logic              ble_reset;
    } result_t;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESC_TIMEOUT = 3'd0,
        CFG_BMS_TIMEOUT = 3'd1,
        CFG_BLE_TIMEOUT = 3'd2,
        CFG_BLE_RESET   = 3'd3,
        CFG_DEBOUNCE    = 3'd4,
        CFG_OVER_TEMP   = 3'd5,
        CFG_CTRL_TEMP   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [8:0]  esc_timeout_limit;
        logic [10:0] bms_timeout_limit;
        logic [12:0] ble_timeout_limit;
        logic [9:0]  ble_reset_count;
        logic [6:0]  debounce_count;
        logic [7:0]  over_temp_limit;
        logic [7:0]  ctrl_temp_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        esc_timeout_limit: 9'd300,
        bms_timeout_limit: 11'd500,
        ble_timeout_limit: 13'd300,
        ble_reset_count:   10'd1000,
        debounce_count:    7'd100,
        over_temp_limit:   8'd180,
        ctrl_temp_limit:   8'd135
    };

    // Silence counter saturation points
    localparam logic [8:0]  ESC_SAT = 9'd500;
    localparam logic [10:0] BMS_SAT = 11'd1500;
    localparam logic [12:0] BLE_SAT = 13'd7500;

    // Motor controller error codes
    localparam logic [7:0] CODE_PHASE_A = 8'd11;
    localparam logic [7:0] CODE_PHASE_B = 8'd13;
    localparam logic [7:0] CODE_PHASE_C = 8'd18;
    localparam logic [7:0] CODE_PHASE_D = 8'd24;
    localparam logic [7:0] CODE_HALL    = 8'd55;

    // Temperature readings that flag a bad sensor
    localparam logic [7:0] TEMP_BAD_A = 8'd253;
    localparam logic [7:0] TEMP_BAD_B = 8'd254;

    // Fault flag bit positions
    localparam int unsigned FB_ESC      = 0;
    localparam int unsigned FB_BMS      = 1;
    localparam int unsigned FB_BLE      = 2;
    localparam int unsigned FB_CODE_A   = 3;
    localparam int unsigned FB_CODE_B   = 4;
    localparam int unsigned FB_CODE_C   = 5;
    localparam int unsigned FB_CODE_D   = 6;
    localparam int unsigned FB_RDY_CHG  = 7;
    localparam int unsigned FB_HALL     = 8;
    localparam int unsigned FB_TSENSOR  = 9;
    localparam int unsigned FB_OVERTEMP = 10;
    localparam int unsigned FB_PACK     = 11;
    localparam int unsigned FB_CTRLTEMP = 12;

endpackage

@@ design/cfm_stream_if.sv @@
// cfm_stream_if: valid/ready channel carrying one item of a given payload type.
// Payload types come from cfm_pkg.

interface cfm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/comms_fault_monitor.sv @@
// comms_fault_monitor: link timeout, motor code and debounced sensor fault monitor.
// Result path: accepted item into the input reg, then its result into the result reg.
// Throughput: one tick item per cycle while result_out is not stalled; the tick logic
// is a single short pass between the input register and the result register.
// Reset (rst_n low, async): counters and fault word cleared, registers at defaults.
// Depends on cfm_pkg, cfm_stream_if, cfm_cfg_regs, cfm_tick_core.

module comms_fault_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    cfm_stream_if.sink                      tick_in,
    cfm_stream_if.source                    result_out,
    input  logic                            cfg_we,
    input  logic [cfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    cfm_pkg::cfg_t       cfg;
    cfm_pkg::tick_item_t in_item_reg;
    cfm_pkg::result_t    out_data_reg;
    cfm_pkg::result_t    core_result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;

    cfm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held item is processed (state commits) exactly when its result
    // moves into the result register, so items see state in order.
    assign out_load      = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign tick_in.ready = !in_valid_reg || out_load;

    cfm_tick_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (out_load),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (tick_in.ready)
        begin
            in_valid_next = tick_in.valid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (tick_in.ready && tick_in.valid)
        begin
            in_item_reg <= tick_in.data;
        end
        if (out_load)
        begin
            out_data_reg <= core_result;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

endmodule

@@ design/cfm_cfg_regs.sv @@
// cfm_cfg_regs: configuration register file, write-only, reset to defaults.
// Depends on cfm_pkg.

module cfm_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cfm_pkg::cfg_t                   cfg
);

    cfm_pkg::cfg_t cfg_reg;
    cfm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cfm_pkg::CFG_ESC_TIMEOUT: cfg_next.esc_timeout_limit = cfg_wdata[8:0];
                cfm_pkg::CFG_BMS_TIMEOUT: cfg_next.bms_timeout_limit = cfg_wdata[10:0];
                cfm_pkg::CFG_BLE_TIMEOUT: cfg_next.ble_timeout_limit = cfg_wdata[12:0];
                cfm_pkg::CFG_BLE_RESET:   cfg_next.ble_reset_count   = cfg_wdata[9:0];
                cfm_pkg::CFG_DEBOUNCE:    cfg_next.debounce_count    = cfg_wdata[6:0];
                cfm_pkg::CFG_OVER_TEMP:   cfg_next.over_temp_limit   = cfg_wdata[7:0];
                cfm_pkg::CFG_CTRL_TEMP:   cfg_next.ctrl_temp_limit   = cfg_wdata[7:0];
                default:                  cfg_next = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cfm_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/cfm_debounce.sv @@
// cfm_debounce: 7-bit wrapping debounce counter; fire when the count is reached.
// Depends on nothing outside this file.

module cfm_debounce (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [6:0] limit,
    output logic       fire
);

    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic [6:0] count_inc;

    assign count_inc = count_reg + 7'd1;
    assign fire      = (count_inc >= limit);

    always_comb
    begin
        count_next = count_reg;
        if (step)
        begin
            count_next = fire ? 7'd0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 7'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ design/cfm_tick_core.sv @@
// cfm_tick_core: per-tick state (silence counters, watchdog, fault word) and
// the fault logic. Depends on cfm_pkg and cfm_debounce.

module cfm_tick_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 process,
    input  cfm_pkg::tick_item_t  item,
    input  cfm_pkg::cfg_t        cfg,
    output cfm_pkg::result_t     result
);

    logic [8:0]  esc_sil_reg, esc_sil_next, esc_clr, esc_inc;
    logic [10:0] bms_sil_reg, bms_sil_next, bms_clr, bms_inc;
    logic [12:0] ble_sil_reg, ble_sil_next, ble_clr, ble_inc;
    logic [9:0]  dead_reg, dead_next, dead_inc;
    logic [cfm_pkg::FLAG_W-1:0] fault_reg, fault_next;

    logic ble_hit, pulse;
    logic sensor_err, ot_cond, pw_cond, ct_cond;
    logic ts_fire, ot_fire, pw_fire, ct_fire;

    // Condition decode
    assign sensor_err = (item.motor_temp == cfm_pkg::TEMP_BAD_A) ||
                        (item.motor_temp == cfm_pkg::TEMP_BAD_B);
    assign ot_cond    = !sensor_err && (item.motor_temp > cfg.over_temp_limit);
    assign pw_cond    = item.pack_warn_a && item.pack_warn_b;
    assign ct_cond    = (item.ctrl_temp > cfg.ctrl_temp_limit) &&
                        (item.ctrl_temp != cfm_pkg::TEMP_BAD_A) &&
                        (item.ctrl_temp != cfm_pkg::TEMP_BAD_B);

    cfm_debounce u_db_tsensor (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process && sensor_err),
        .limit (cfg.debounce_count),
        .fire  (ts_fire)
    );

    cfm_debounce u_db_overtemp (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process && ot_cond),
        .limit (cfg.debounce_count),
        .fire  (ot_fire)
    );

    cfm_debounce u_db_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process && pw_cond),
        .limit (cfg.debounce_count),
        .fire  (pw_fire)
    );

    cfm_debounce u_db_ctrltemp (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (process && ct_cond),
        .limit (cfg.debounce_count),
        .fire  (ct_fire)
    );

    // Silence counters: clear on frame, then count up to saturation
    always_comb
    begin
        esc_clr = item.esc_rx ? 9'd0  : esc_sil_reg;
        bms_clr = item.bms_rx ? 11'd0 : bms_sil_reg;
        ble_clr = item.ble_rx ? 13'd0 : ble_sil_reg;
        esc_inc = (esc_clr < cfm_pkg::ESC_SAT) ? esc_clr + 9'd1  : esc_clr;
        bms_inc = (bms_clr < cfm_pkg::BMS_SAT) ? bms_clr + 11'd1 : bms_clr;
        ble_inc = (ble_clr < cfm_pkg::BLE_SAT) ? ble_clr + 13'd1 : ble_clr;
    end

    // Wireless dead-link watchdog
    always_comb
    begin
        ble_hit      = (ble_inc >= cfg.ble_timeout_limit);
        dead_inc     = dead_reg + 10'd1;
        pulse        = 1'b0;
        dead_next    = 10'd0;
        ble_sil_next = ble_inc;
        if (ble_hit)
        begin
            if (dead_inc >= cfg.ble_reset_count)
            begin
                pulse        = 1'b1;
                ble_sil_next = 13'd0;
            end
            else
            begin
                dead_next = dead_inc;
            end
        end
        esc_sil_next = esc_inc;
        bms_sil_next = bms_inc;
    end

    // Fault word
    always_comb
    begin
        fault_next = fault_reg;
        fault_next[cfm_pkg::FB_ESC]     = (esc_inc >= cfg.esc_timeout_limit);
        fault_next[cfm_pkg::FB_BMS]     = (bms_inc >= cfg.bms_timeout_limit);
        fault_next[cfm_pkg::FB_BLE]     = ble_hit;
        fault_next[cfm_pkg::FB_CODE_A]  = (item.motor_error == cfm_pkg::CODE_PHASE_A);
        fault_next[cfm_pkg::FB_CODE_B]  = (item.motor_error == cfm_pkg::CODE_PHASE_B);
        fault_next[cfm_pkg::FB_CODE_C]  = (item.motor_error == cfm_pkg::CODE_PHASE_C);
        fault_next[cfm_pkg::FB_CODE_D]  = (item.motor_error == cfm_pkg::CODE_PHASE_D);
        fault_next[cfm_pkg::FB_RDY_CHG] = item.vehicle_ready && item.charging;
        fault_next[cfm_pkg::FB_HALL]    = (item.motor_error == cfm_pkg::CODE_HALL);
        // sensor error freezes the over-temperature path
        if (sensor_err)
        begin
            fault_next[cfm_pkg::FB_TSENSOR] = fault_reg[cfm_pkg::FB_TSENSOR] | ts_fire;
        end
        else
        begin
            fault_next[cfm_pkg::FB_TSENSOR]  = 1'b0;
            fault_next[cfm_pkg::FB_OVERTEMP] = ot_cond &&
                                               (fault_reg[cfm_pkg::FB_OVERTEMP] | ot_fire);
        end
        fault_next[cfm_pkg::FB_PACK]     = pw_cond && (fault_reg[cfm_pkg::FB_PACK] | pw_fire);
        fault_next[cfm_pkg::FB_CTRLTEMP] = ct_cond &&
                                           (fault_reg[cfm_pkg::FB_CTRLTEMP] | ct_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_sil_reg <= 9'd0;
            bms_sil_reg <= 11'd0;
            ble_sil_reg <= 13'd0;
            dead_reg    <= 10'd0;
            fault_reg   <= '0;
        end
        else if (process)
        begin
            esc_sil_reg <= esc_sil_next;
            bms_sil_reg <= bms_sil_next;
            ble_sil_reg <= ble_sil_next;
            dead_reg    <= dead_next;
            fault_reg   <= fault_next;
        end
    end

    assign result.fault_flags = fault_next;
    assign result.ble_reset   = pulse;

endmodule

@@ design/cfm_checker.sv @@
// cfm_checker: port-level assertions for comms_fault_monitor, attached by bind.
// Depends on cfm_pkg.

module cfm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [cfm_pkg::FLAG_W-1:0]  fault_flags,
    input logic                        ble_reset
);

    // A stalled result holds its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result holds its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fault_flags) && $stable(ble_reset))
        else $error("result payload changed while stalled");

    // The link reset pulse only fires while the wireless timeout is flagged
    a_pulse_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ble_reset |-> fault_flags[cfm_pkg::FB_BLE])
        else $error("link reset without wireless timeout");

    // Motor code faults are decoded from one code, so at most one is set
    a_code_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({fault_flags[cfm_pkg::FB_HALL],
                                fault_flags[cfm_pkg::FB_CODE_D:cfm_pkg::FB_CODE_A]}))
        else $error("more than one motor code fault");

endmodule

bind comms_fault_monitor cfm_checker u_cfm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .fault_flags (result_out.data.fault_flags),
    .ble_reset   (result_out.data.ble_reset)
);
